@@ design/artbl_pkg.sv @@
// Shared types, codes and defaults for the address reservation guard table.
// Used by every module of the block; depends on nothing.
package artbl_pkg;

    localparam int ENTRY_COUNT_DEF = 64;

    typedef enum logic {
        CMD_RESERVE = 1'b0,
        CMD_SETTLE  = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        ST_SUCCESS     = 2'd0,
        ST_ERROR       = 2'd1,
        ST_UNSUPPORTED = 2'd2,
        ST_NO_EFFECT   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        PH_PENDING   = 2'd0,
        PH_INSTALLED = 2'd1,
        PH_TAINTED   = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        OC_RESERVED      = 3'd0,
        OC_DUP_PENDING   = 3'd1,
        OC_DUP_INSTALLED = 3'd2,
        OC_DUP_TAINTED   = 3'd3,
        OC_BLOCKED       = 3'd4,
        OC_FULL          = 3'd5
    } outcome_t;

    typedef enum logic [2:0] {
        CS_CLEAR,
        CS_IDLE,
        CS_SCAN,
        CS_FETCH,
        CS_APPLY
    } ctrl_state_t;

    // One table slot as held in the memory word
    typedef struct packed {
        logic        used;
        logic [63:0] address;
        logic [63:0] replacement;
        logic [63:0] original;
        logic [7:0]  backend;
        phase_t      phase;
        logic [63:0] generation;
        logic [63:0] previous;
        logic        has_previous;
    } entry_t;

    typedef struct packed {
        cmd_t        command;
        logic [63:0] address;
        logic [63:0] replacement;
        logic [7:0]  backend_type;
        logic [63:0] token;
        status_t     settle_status;
        logic [63:0] original_value;
    } item_t;

    typedef struct packed {
        outcome_t    outcome;
        logic [63:0] generation;
        logic [63:0] original;
        logic        original_valid;
    } result_t;

    // Scan summary handed from the controller to the update logic
    typedef struct packed {
        logic match_found;
        logic free_found;
    } scan_t;

    // Update decision: write-back and result beat
    typedef struct packed {
        logic    wr_en;
        logic    res_valid;
        result_t res;
        entry_t  ent;
    } upd_t;

endpackage

@@ design/artbl_mem.sv @@
// Slot table memory: one write port, one read port with registered data.
// Depends on artbl_pkg for the entry layout.
module artbl_mem #(
    parameter int DEPTH  = artbl_pkg::ENTRY_COUNT_DEF,
    parameter int ADDR_W = 6
) (
    input  logic                 aclk,
    input  logic                 rd_en,
    input  logic [ADDR_W-1:0]    rd_addr,
    output artbl_pkg::entry_t    rd_data,
    input  logic                 wr_en,
    input  logic [ADDR_W-1:0]    wr_addr,
    input  artbl_pkg::entry_t    wr_data
);
    import artbl_pkg::*;

    entry_t ram_reg [DEPTH];
    entry_t rd_data_reg;

    // Write one slot
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ram_reg[wr_addr] <= wr_data;
        end
    end

    // Read one slot; the read data is registered
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= ram_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/artbl_update.sv @@
// Read-modify-write decision for one command on the selected slot.
// Depends on artbl_pkg for entry, item, scan and update types.
module artbl_update (
    input  artbl_pkg::item_t  item,
    input  artbl_pkg::entry_t ent,
    input  artbl_pkg::scan_t  scan,
    output artbl_pkg::upd_t   upd
);
    import artbl_pkg::*;

    logic [63:0] gen_inc;

    assign gen_inc = ent.generation + 64'd1;

    always_comb begin
        upd     = '0;
        upd.ent = ent;
        case (item.command)
            CMD_RESERVE: begin
                upd.res_valid   = 1'b1;
                upd.res.outcome = OC_BLOCKED;
                if (scan.match_found) begin
                    if (ent.replacement == item.replacement) begin
                        // Same replacement already present: report by phase
                        if (ent.phase == PH_PENDING) begin
                            upd.res.outcome = OC_DUP_PENDING;
                        end else begin
                            upd.res.outcome = (ent.phase == PH_INSTALLED) ?
                                              OC_DUP_INSTALLED : OC_DUP_TAINTED;
                            upd.res.original       = ent.original;
                            upd.res.original_valid = 1'b1;
                        end
                    end else if (ent.phase == PH_INSTALLED &&
                                 ent.backend == item.backend_type) begin
                        // Chain the new replacement over the installed one
                        upd.wr_en              = 1'b1;
                        upd.ent.previous       = ent.replacement;
                        upd.ent.has_previous   = 1'b1;
                        upd.ent.replacement    = item.replacement;
                        upd.ent.phase          = PH_PENDING;
                        upd.ent.generation     = gen_inc;
                        upd.res.outcome        = OC_RESERVED;
                        upd.res.generation     = gen_inc;
                    end
                end else if (scan.free_found) begin
                    // Claim the lowest free slot
                    upd.wr_en            = 1'b1;
                    upd.ent.used         = 1'b1;
                    upd.ent.address      = item.address;
                    upd.ent.replacement  = item.replacement;
                    upd.ent.original     = '0;
                    upd.ent.backend      = item.backend_type;
                    upd.ent.phase        = PH_PENDING;
                    upd.ent.previous     = '0;
                    upd.ent.has_previous = 1'b0;
                    upd.ent.generation   = gen_inc;
                    upd.res.outcome      = OC_RESERVED;
                    upd.res.generation   = gen_inc;
                end else begin
                    upd.res.outcome = OC_FULL;
                end
            end
            CMD_SETTLE: begin
                if (scan.match_found && ent.generation == item.token) begin
                    case (item.settle_status)
                        ST_SUCCESS: begin
                            upd.wr_en            = 1'b1;
                            upd.ent.original     = item.original_value;
                            upd.ent.has_previous = 1'b0;
                            upd.ent.phase        = PH_INSTALLED;
                        end
                        ST_ERROR: begin
                            upd.wr_en            = 1'b1;
                            upd.ent.has_previous = 1'b0;
                            upd.ent.phase        = PH_TAINTED;
                        end
                        ST_UNSUPPORTED: begin
                            upd.wr_en = 1'b1;
                            if (ent.phase == PH_PENDING && !ent.has_previous) begin
                                // Release; generation is kept for the next claim
                                upd.ent.used = 1'b0;
                            end else if (ent.phase == PH_PENDING) begin
                                // Restore the chained owner
                                upd.ent.replacement  = ent.previous;
                                upd.ent.has_previous = 1'b0;
                                upd.ent.phase        = PH_INSTALLED;
                            end else begin
                                upd.ent.phase = PH_TAINTED;
                            end
                        end
                        default: begin
                            upd.wr_en = 1'b0;
                        end
                    endcase
                end
            end
            default: begin
                upd.res_valid = 1'b0;
            end
        endcase
    end

endmodule

@@ design/artbl_ctrl.sv @@
// Sequencer: clearing pass, table scan, slot fetch, write-back and result register.
// Depends on artbl_pkg; drives artbl_mem and consumes artbl_update's decision.
module artbl_ctrl #(
    parameter int ENTRY_COUNT = artbl_pkg::ENTRY_COUNT_DEF,
    parameter int IDX_W       = 6
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  artbl_pkg::item_t     s_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output artbl_pkg::result_t   m_result,
    output artbl_pkg::item_t     item_q,
    output artbl_pkg::scan_t     scan_q,
    input  artbl_pkg::upd_t      upd,
    output logic                 mem_rd_en,
    output logic [IDX_W-1:0]     mem_rd_addr,
    input  artbl_pkg::entry_t    mem_rd_data,
    output logic                 mem_wr_en,
    output logic [IDX_W-1:0]     mem_wr_addr,
    output artbl_pkg::entry_t    mem_wr_data
);
    import artbl_pkg::*;

    localparam int CNT_W = $clog2(ENTRY_COUNT + 1);
    localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(ENTRY_COUNT);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ENTRY_COUNT - 1);

    ctrl_state_t       state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              data_vld_reg;
    logic [IDX_W-1:0]  data_idx_reg;
    logic              match_found_reg, match_found_next;
    logic [IDX_W-1:0]  match_idx_reg, match_idx_next;
    logic              free_found_reg, free_found_next;
    logic [IDX_W-1:0]  free_idx_reg, free_idx_next;
    item_t             item_reg;
    logic              m_valid_reg, m_valid_next;
    result_t           m_result_reg;

    logic              accept;
    logic              advance;
    logic              scan_rd;
    logic [IDX_W-1:0]  cnt_idx;
    logic [IDX_W-1:0]  sel_idx;

    assign accept  = s_valid && s_ready;
    assign advance = !upd.res_valid || !m_valid_reg || m_ready;
    assign scan_rd = (state_reg == CS_SCAN) && (cnt_reg != CNT_END);
    assign cnt_idx = cnt_reg[IDX_W-1:0];
    assign sel_idx = match_found_reg ? match_idx_reg : free_idx_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            CS_CLEAR: if (cnt_reg == CNT_LAST) state_next = CS_IDLE;
            CS_IDLE:  if (s_valid)             state_next = CS_SCAN;
            CS_SCAN:  if (cnt_reg == CNT_END)  state_next = CS_FETCH;
            CS_FETCH:                          state_next = CS_APPLY;
            CS_APPLY: if (advance)             state_next = CS_IDLE;
            default:                           state_next = CS_CLEAR;
        endcase
    end

    // Outputs and memory port control
    always_comb begin
        s_ready     = 1'b0;
        mem_rd_en   = 1'b0;
        mem_rd_addr = cnt_idx;
        mem_wr_en   = 1'b0;
        mem_wr_addr = sel_idx;
        mem_wr_data = upd.ent;
        case (state_reg)
            CS_CLEAR: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = cnt_idx;
                mem_wr_data = '0;
            end
            CS_IDLE: begin
                s_ready = 1'b1;
            end
            CS_SCAN: begin
                mem_rd_en = scan_rd;
            end
            CS_FETCH: begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = sel_idx;
            end
            CS_APPLY: begin
                mem_wr_en = advance && upd.wr_en;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // Counter: clearing sweep and scan read index
    always_comb begin
        cnt_next = cnt_reg;
        if (accept) begin
            cnt_next = '0;
        end else if (state_reg == CS_CLEAR || state_reg == CS_SCAN) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    // Track first matching used slot and first free slot
    always_comb begin
        match_found_next = match_found_reg;
        match_idx_next   = match_idx_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        if (accept) begin
            match_found_next = 1'b0;
            free_found_next  = 1'b0;
        end else if (data_vld_reg) begin
            if (mem_rd_data.used && mem_rd_data.address == item_reg.address &&
                !match_found_reg) begin
                match_found_next = 1'b1;
                match_idx_next   = data_idx_reg;
            end
            if (!mem_rd_data.used && !free_found_reg) begin
                free_found_next = 1'b1;
                free_idx_next   = data_idx_reg;
            end
        end
    end

    // Result register: load in the apply step of a reserve, drop when taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (state_reg == CS_APPLY && advance && upd.res_valid) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= CS_CLEAR;
            cnt_reg         <= '0;
            data_vld_reg    <= 1'b0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            data_vld_reg    <= scan_rd;
            match_found_reg <= match_found_next;
            free_found_reg  <= free_found_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        data_idx_reg  <= cnt_idx;
        match_idx_reg <= match_idx_next;
        free_idx_reg  <= free_idx_next;
        if (accept) begin
            item_reg <= s_item;
        end
        if (state_reg == CS_APPLY && advance && upd.res_valid) begin
            m_result_reg <= upd.res;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_result = m_result_reg;
    assign item_q   = item_reg;
    assign scan_q   = '{match_found: match_found_reg, free_found: free_found_reg};

endmodule

@@ design/address_reservation_guard_table.sv @@
// Address reservation guard table: ENTRY_COUNT slots held in one synchronous
// memory, searched one slot per clock. After reset the block sweeps the memory
// once, with s_ready low, to clear the used, generation and chain bits. Each
// command then runs a full scan through the single read port, a re-read of the
// chosen slot and a write-back; for a reserve this last step waits while an
// earlier result beat is still untaken. A reserve yields one result beat; a
// settle yields none. The next command is accepted while a result beat still
// waits in the output register.
// Depends on artbl_pkg, artbl_mem, artbl_update and artbl_ctrl.
module address_reservation_guard_table #(
    parameter int ENTRY_COUNT = artbl_pkg::ENTRY_COUNT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_command,
    input  logic [63:0] s_address,
    input  logic [63:0] s_replacement,
    input  logic [7:0]  s_backend_type,
    input  logic [63:0] s_token,
    input  logic [1:0]  s_settle_status,
    input  logic [63:0] s_original_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_outcome,
    output logic [63:0] m_generation_out,
    output logic [63:0] m_original_out,
    output logic        m_original_valid
);
    import artbl_pkg::*;

    localparam int IDX_W = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;

    item_t            s_item;
    item_t            item_q;
    scan_t            scan_q;
    upd_t             upd;
    result_t          m_result;
    logic             mem_rd_en;
    logic [IDX_W-1:0] mem_rd_addr;
    entry_t           mem_rd_data;
    logic             mem_wr_en;
    logic [IDX_W-1:0] mem_wr_addr;
    entry_t           mem_wr_data;

    // Gather the input beat
    always_comb begin
        s_item.command        = cmd_t'(s_command);
        s_item.address        = s_address;
        s_item.replacement    = s_replacement;
        s_item.backend_type   = s_backend_type;
        s_item.token          = s_token;
        s_item.settle_status  = status_t'(s_settle_status);
        s_item.original_value = s_original_value;
    end

    artbl_ctrl #(
        .ENTRY_COUNT (ENTRY_COUNT),
        .IDX_W       (IDX_W)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_item      (s_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_result    (m_result),
        .item_q      (item_q),
        .scan_q      (scan_q),
        .upd         (upd),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data)
    );

    artbl_mem #(
        .DEPTH  (ENTRY_COUNT),
        .ADDR_W (IDX_W)
    ) u_mem (
        .aclk    (aclk),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    artbl_update u_update (
        .item (item_q),
        .ent  (mem_rd_data),
        .scan (scan_q),
        .upd  (upd)
    );

    // Split the result beat onto its ports
    assign m_outcome        = m_result.outcome;
    assign m_generation_out = m_result.generation;
    assign m_original_out   = m_result.original;
    assign m_original_valid = m_result.original_valid;

endmodule

@@ design/artbl_checker.sv @@
// Port-level checks for the address reservation guard table, bound to the top.
// Depends on artbl_pkg for outcome codes.
module artbl_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_outcome,
    input logic [63:0] m_generation_out,
    input logic [63:0] m_original_out,
    input logic        m_original_valid
);
    import artbl_pkg::*;

    // Hold a result beat until it is taken
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_outcome))
        else $error("result beat dropped or changed while stalled");

    // Clearing pass keeps the input closed right after reset
    a_clear_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("input ready during clearing pass");

    // Stored original is flagged only on installed or tainted duplicates
    a_original_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_original_valid ==
            (m_outcome == OC_DUP_INSTALLED || m_outcome == OC_DUP_TAINTED)))
        else $error("original_valid disagrees with outcome");

    // Generation is reported only on a reservation
    a_generation_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_outcome != OC_RESERVED) |-> m_generation_out == 64'd0)
        else $error("generation reported without reservation");

    // Original stays zero when it is not flagged
    a_original_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_original_valid |-> m_original_out == 64'd0)
        else $error("original reported without flag");

endmodule

bind address_reservation_guard_table artbl_checker u_artbl_checker (.*);
